FILE: rtl/bha_pkg.sv
package bha_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_BINS   = 64;
    localparam int DEF_NUM_SERIES = 8;
    localparam int DEF_COUNT_BITS = 32;

    // divider geometry
    localparam int DIV_W     = 64;
    localparam int DIV_LEN_W = 7;
    localparam int NUMER_W   = 40;
    localparam logic [DIV_LEN_W-1:0] DIV_LEN_SHORT = DIV_LEN_W'(NUMER_W);
    localparam logic [DIV_LEN_W-1:0] DIV_LEN_LONG  = DIV_LEN_W'(DIV_W);

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [1:0] CFG_BINS       = 2'd2;

    // request actions
    localparam logic [1:0] ACT_ADD     = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_SUMMARY = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_BIN   = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         series_id;
        logic signed [31:0] sample;
        logic [5:0]         bin_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        bin_total;
        logic signed [31:0] bin_edge;
        logic [31:0]        points_seen;
        logic signed [31:0] mean_value;
    } t_out_item;

    // work kinds after classification
    typedef enum logic [1:0] {
        OP_ADD,
        OP_RBIN,
        OP_SUMMARY,
        OP_REPLY
    } t_op;

    // classified request passed from front to back
    typedef struct packed {
        t_op                op;
        logic [1:0]         status;
        logic [2:0]         series;
        logic signed [31:0] sample;
        logic [6:0]         bin_lim;
        logic [5:0]         bin_idx;
        logic signed [31:0] lo;
        logic [NUMER_W-1:0] numer;
        logic [31:0]        denom;
    } t_job;

    typedef struct packed {
        logic                 start;
        logic [DIV_LEN_W-1:0] len;
        logic [DIV_W-1:0]     numer;
        logic [DIV_W-1:0]     denom;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PREP,
        B_DIV,
        B_READ,
        B_OUT
    } t_bstate;

endpackage

FILE: rtl/binned_histogram_accumulator.sv
// channel    direction  handshake              payload
// in         request    i_in_valid/o_in_stall  i_in_item (t_in_item)
// out        result     o_out_valid/i_out_stall o_out_item (t_out_item)
// cfg        write      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// add and read-bin requests and summaries wait on the shared divider, which
// produces one quotient bit per cycle (40 or 64 bits)
// requests that need no division skip the divider
// after reset a clearing pass of NUM_SERIES*MAX_BINS entries runs, in stall
// the front keeps accepting into a two-entry queue while the back works, and a
// finished result waits in the output register; a later one waits in B_OUT
module binned_histogram_accumulator import bha_pkg::*; #(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int NUM_SERIES = DEF_NUM_SERIES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic     clearing;
    logic     q_push, q_pop, q_full, q_empty;
    t_job     q_data, q_head;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // accept and classify
    bha_front #(
        .MAX_BINS   (MAX_BINS),
        .NUM_SERIES (NUM_SERIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_clearing  (clearing),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_data)
    );

    // job queue between the halves
    bha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // shared iterative divider
    bha_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // stores and result
    bha_back #(
        .MAX_BINS   (MAX_BINS),
        .NUM_SERIES (NUM_SERIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // no request taken while the stores are being cleared
    a_stall_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> o_in_stall)
        else $error("request accepted during clearing pass");

    // divider is never restarted mid-division
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // queue discipline on both sides
    a_q_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_q_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

FILE: rtl/bha_queue.sv
module bha_queue import bha_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;

    // pointer advance with wrap
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

endmodule

FILE: rtl/bha_div.sv
module bha_div import bha_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_LEN_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_n;
    logic [DIV_W-1:0]     r_d;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [DIV_W-1:0]     r_q;
    logic [DIV_W:0]       sh;
    logic                 ge;

    // one restoring step per cycle
    always_comb begin
        sh    = {r_rem, r_n[DIV_W-1]};
        ge    = (sh >= {1'b0, r_d});
        n_rem = ge ? DIV_W'(sh - {1'b0, r_d}) : sh[DIV_W-1:0];
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend is left aligned so only len steps are needed
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_n   <= i_req.numer << (DIV_LEN_LONG - i_req.len);
            r_d   <= i_req.denom;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_n   <= r_n << 1;
            r_rem <= n_rem;
            r_q   <= {r_q[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: rtl/bha_front.sv
module bha_front import bha_pkg::*; #(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int NUM_SERIES = DEF_NUM_SERIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_clearing,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_job        o_q_data
);

    logic               r_valid;
    t_in_item           r_in;
    logic signed [31:0] r_lo;
    logic signed [31:0] r_hi;
    logic [6:0]         r_bins;

    logic               accept;
    logic signed [31:0] lo, hi, x;
    logic [32:0]        span;
    logic [32:0]        diff;
    logic [31:0]        range_w;
    logic [6:0]         bins_eff;
    logic               in_range;
    logic [31:0]        mul_a;
    logic [6:0]         mul_b;
    logic [38:0]        prod;
    t_job               job;

    // series number folded into the configured series count
    function automatic logic [2:0] wrap_series(input logic [2:0] s);
        logic [2:0] v;
        v = s;
        for (int k = 0; k < 8; k++) begin
            if (32'(v) >= NUM_SERIES) begin
                v = v - 3'(NUM_SERIES);
            end
        end
        return v;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_clearing || (r_valid && i_q_full);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_q_push    = r_valid && !i_q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo   <= 32'sd0;
            r_hi   <= 32'sd65536;
            r_bins <= 7'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RANGE_LOW:  r_lo <= i_cfg_data;
                CFG_RANGE_HIGH: r_hi <= i_cfg_data;
                CFG_BINS:       r_bins <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // input holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_item;
        end
    end

    // range, bin count and the one shared multiply
    always_comb begin
        lo   = r_lo;
        hi   = r_hi;
        x    = r_in.sample;
        span = {hi[31], hi} - {lo[31], lo};
        diff = {x[31], x} - {lo[31], lo};
        range_w = (hi >= lo) ? span[31:0] : '0;
        in_range = (x >= lo) && (x <= hi);
        if (r_bins == 7'd0) begin
            bins_eff = 7'd1;
        end else if (32'(r_bins) > MAX_BINS) begin
            bins_eff = 7'(MAX_BINS);
        end else begin
            bins_eff = r_bins;
        end
        mul_a = (r_in.action == ACT_ADD) ? diff[31:0] : range_w;
        mul_b = (r_in.action == ACT_ADD) ? bins_eff : {1'b0, r_in.bin_index};
        prod  = 39'(mul_a * mul_b);
    end

    // classification into a back end job
    always_comb begin
        job         = '0;
        job.series  = wrap_series(r_in.series_id);
        job.sample  = x;
        job.bin_lim = bins_eff - 7'd1;
        job.bin_idx = r_in.bin_index;
        job.lo      = lo;
        job.numer   = NUMER_W'(prod);
        unique case (r_in.action)
            ACT_ADD: begin
                if (in_range) begin
                    job.op    = OP_ADD;
                    job.denom = (range_w == '0) ? 32'd1 : range_w;
                end else begin
                    job.op     = OP_REPLY;
                    job.status = ST_RANGE;
                end
            end
            ACT_READ: begin
                if ({1'b0, r_in.bin_index} >= bins_eff) begin
                    job.op     = OP_REPLY;
                    job.status = ST_BIN;
                end else begin
                    job.op    = OP_RBIN;
                    job.denom = 32'(bins_eff);
                end
            end
            ACT_SUMMARY: begin
                job.op = OP_SUMMARY;
            end
            ACT_NONE: begin
                job.op     = OP_REPLY;
                job.status = ST_OK;
            end
        endcase
    end

    assign o_q_data = job;

endmodule

FILE: rtl/bha_back.sv
module bha_back import bha_pkg::*; #(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int NUM_SERIES = DEF_NUM_SERIES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_job      i_q_head,
    output logic      o_q_pop,
    output t_div_req  o_div_req,
    input  t_div_rsp  i_div_rsp,
    output logic      o_clearing,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int BIN_DEPTH = NUM_SERIES * MAX_BINS;
    localparam int ADDR_W    = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int SER_W     = (NUM_SERIES > 1) ? $clog2(NUM_SERIES) : 1;

    t_bstate r_state, n_state;
    t_job    r_job;

    logic [ADDR_W-1:0]     r_clr_idx;
    logic [COUNT_BITS-1:0] bin_mem [BIN_DEPTH];
    logic [63:0]           sum_mem [NUM_SERIES];
    logic [COUNT_BITS-1:0] pts_mem [NUM_SERIES];
    logic [COUNT_BITS-1:0] r_bin_rd;
    logic [COUNT_BITS-1:0] r_pts_rd;
    logic [63:0]           r_sum_rd;
    logic                  r_neg;
    logic [31:0]           r_pts_out;
    t_out_item             r_res, n_res;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic                  res_we;
    logic                  rd_en;
    logic                  out_load;
    logic                  bin_we;
    logic [ADDR_W-1:0]     bin_wa;
    logic [COUNT_BITS-1:0] bin_wd;
    logic                  ser_we;
    logic [SER_W-1:0]      ser_wa;
    logic [63:0]           sum_wd;
    logic [COUNT_BITS-1:0] pts_wd;

    logic [SER_W-1:0]      ser_idx;
    logic [6:0]            bin_sel;
    logic [6:0]            bin_off;
    logic [ADDR_W-1:0]     bin_addr;
    logic [64:0]           s65;
    logic [63:0]           sum_new;
    logic [63:0]           mag;
    logic [63:0]           q;
    logic [31:0]           qc;
    logic [31:0]           mean;
    logic                  clr_last;

    // counts wider than the result field report the field maximum
    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // addresses and arithmetic on read data
    always_comb begin
        q        = i_div_rsp.quot;
        ser_idx  = SER_W'(r_job.series);
        bin_sel  = (q > 64'(r_job.bin_lim)) ? r_job.bin_lim : q[6:0];
        bin_off  = (r_job.op == OP_ADD) ? bin_sel : {1'b0, r_job.bin_idx};
        bin_addr = ADDR_W'(ADDR_W'(ser_idx) * ADDR_W'(MAX_BINS)) + ADDR_W'(bin_off);
        s65 = {r_sum_rd[63], r_sum_rd} + {{33{r_job.sample[31]}}, r_job.sample};
        if (s65[64] != s65[63]) begin
            sum_new = s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sum_new = s65[63:0];
        end
        mag = r_sum_rd[63] ? (~r_sum_rd + 64'd1) : r_sum_rd;
        if (q > 64'h0000_0000_8000_0000) begin
            qc = 32'h8000_0000;
        end else begin
            qc = q[31:0];
        end
        if (!r_neg && (q > 64'h0000_0000_7FFF_FFFF)) begin
            qc = 32'h7FFF_FFFF;
        end
        mean     = r_neg ? (~qc + 32'd1) : qc;
        clr_last = (r_clr_idx == ADDR_W'(BIN_DEPTH - 1));
        out_load = !r_out_valid || !i_out_stall;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_CLEAR: begin
                if (clr_last) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = B_PREP;
                end
            end
            B_PREP: begin
                unique case (r_job.op)
                    OP_REPLY:   n_state = B_OUT;
                    OP_SUMMARY: n_state = B_READ;
                    OP_ADD,
                    OP_RBIN:    n_state = B_DIV;
                endcase
            end
            B_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = (r_job.op == OP_SUMMARY) ? B_OUT : B_READ;
                end
            end
            B_READ: begin
                if (r_job.op == OP_SUMMARY && r_pts_rd != '0) begin
                    n_state = B_DIV;
                end else begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (out_load) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop   = 1'b0;
        o_div_req = '0;
        rd_en     = 1'b0;
        res_we    = 1'b0;
        n_res     = '0;
        bin_we    = 1'b0;
        bin_wa    = bin_addr;
        bin_wd    = (r_bin_rd == '1) ? r_bin_rd : r_bin_rd + 1'b1;
        ser_we    = 1'b0;
        ser_wa    = ser_idx;
        sum_wd    = sum_new;
        pts_wd    = r_pts_rd + 1'b1;
        unique case (r_state)
            B_CLEAR: begin
                bin_we = 1'b1;
                bin_wa = r_clr_idx;
                bin_wd = '0;
                ser_we = (32'(r_clr_idx) < NUM_SERIES);
                ser_wa = SER_W'(r_clr_idx);
                sum_wd = '0;
                pts_wd = '0;
            end
            B_IDLE: begin
                o_q_pop = !i_q_empty;
            end
            B_PREP: begin
                unique case (r_job.op)
                    OP_ADD,
                    OP_RBIN: begin
                        o_div_req.start = 1'b1;
                        o_div_req.len   = DIV_LEN_SHORT;
                        o_div_req.numer = DIV_W'(r_job.numer);
                        o_div_req.denom = DIV_W'(r_job.denom);
                    end
                    OP_SUMMARY: begin
                        rd_en = 1'b1;
                    end
                    OP_REPLY: begin
                        res_we       = 1'b1;
                        n_res.status = r_job.status;
                    end
                endcase
            end
            B_DIV: begin
                if (i_div_rsp.done) begin
                    if (r_job.op == OP_SUMMARY) begin
                        res_we            = 1'b1;
                        n_res.points_seen = r_pts_out;
                        n_res.mean_value  = mean;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            B_READ: begin
                unique case (r_job.op)
                    OP_ADD: begin
                        bin_we       = 1'b1;
                        ser_we       = (r_pts_rd != '1);
                        res_we       = 1'b1;
                        n_res.status = ST_OK;
                    end
                    OP_RBIN: begin
                        res_we          = 1'b1;
                        n_res.bin_total = sat32(64'(r_bin_rd));
                        n_res.bin_edge  = r_job.lo + q[31:0];
                    end
                    OP_SUMMARY: begin
                        if (r_pts_rd == '0) begin
                            res_we = 1'b1;
                        end else begin
                            o_div_req.start = 1'b1;
                            o_div_req.len   = DIV_LEN_LONG;
                            o_div_req.numer = mag;
                            o_div_req.denom = DIV_W'(r_pts_rd);
                        end
                    end
                    OP_REPLY: ;
                endcase
            end
            B_OUT: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == B_OUT && out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // job, result and summary side data
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_q_head;
        end
        if (res_we) begin
            r_res <= n_res;
        end
        if (r_state == B_OUT && out_load) begin
            r_out <= r_res;
        end
        if (r_state == B_READ) begin
            r_neg     <= r_sum_rd[63];
            r_pts_out <= sat32(64'(r_pts_rd));
        end
    end

    // bin count memory
    always_ff @(posedge i_clk) begin
        if (bin_we) begin
            bin_mem[bin_wa] <= bin_wd;
        end
        if (rd_en) begin
            r_bin_rd <= bin_mem[bin_addr];
        end
    end

    // series sum and point count memories
    always_ff @(posedge i_clk) begin
        if (ser_we) begin
            sum_mem[ser_wa] <= sum_wd;
            pts_mem[ser_wa] <= pts_wd;
        end
        if (rd_en) begin
            r_sum_rd <= sum_mem[ser_idx];
            r_pts_rd <= pts_mem[ser_idx];
        end
    end

    assign o_clearing  = (r_state == B_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
